[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`endif

[rtl/kil_pkg.sv]
`default_nettype none

package kil_pkg;

   localparam int DEFAULT_WORD_CAPACITY = 32;
   localparam int KW_COUNT              = 10;
   localparam int KW_MAX_LEN            = 6;
   localparam int KW_POS_W              = $clog2(KW_MAX_LEN);
   localparam int KW_NUM_W              = 4;

   typedef enum logic [1:0] {
      KIND_OPERATOR   = 2'd0,
      KIND_KEYWORD    = 2'd1,
      KIND_IDENTIFIER = 2'd2
   } token_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   // Keyword text, zero padded past the keyword's length.
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
      '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},   // int
      '{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74, 8'h00},   // float
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},   // if
      '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00},   // else
      '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},   // while
      '{8'h64, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00},   // do
      '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00},   // for
      '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},   // return
      '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00},   // char
      '{8'h64, 8'h6f, 8'h75, 8'h62, 8'h6c, 8'h65}    // double
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd4, 3'd6
   };

   function automatic logic is_op_char(input logic [7:0] c);
      logic r;
      r = 1'b0;
      case (c) inside
         8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h25, 8'h3d, 8'h3c, 8'h3e, 8'h26, 8'h7c: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
             (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_end_char(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d) || (c == 8'h3b) || (c == 8'h2c);
   endfunction

endpackage

`default_nettype wire

[rtl/kil_word_ram.sv]
`default_nettype none

module kil_word_ram import kil_pkg::*; #(
   parameter int DEPTH  = DEFAULT_WORD_CAPACITY,
   parameter int ADDR_W = $clog2(DEFAULT_WORD_CAPACITY)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/kil_kw_match.sv]
`default_nettype none

module kil_kw_match import kil_pkg::*; #(
   parameter int LEN_W = $clog2(DEFAULT_WORD_CAPACITY + 1)
) (
   input  wire logic                clock,
   input  wire logic                step,
   input  wire logic [7:0]          char_in,
   input  wire logic [LEN_W-1:0]    word_len,
   output logic                     hit,
   output logic [KW_NUM_W-1:0]      number
);

   logic [KW_COUNT-1:0] cand_ff;
   logic [KW_COUNT-1:0] cand_in;
   logic [KW_COUNT-1:0] col_eq;
   logic [KW_COUNT-1:0] full_eq;

   // Compare the new character with every keyword's column at the current position.
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         col_eq[k] = (word_len < LEN_W'(KW_MAX_LEN)) &&
                     (KW_TEXT[k][word_len[KW_POS_W-1:0]] == char_in);
      end
      cand_in = ((word_len == '0) ? {KW_COUNT{1'b1}} : cand_ff) & col_eq;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         cand_ff <= cand_in;
      end
   end

   always_comb begin
      hit    = 1'b0;
      number = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         full_eq[k] = cand_ff[k] && (word_len == LEN_W'(KW_LEN[k]));
      end
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (full_eq[k]) begin
            hit    = 1'b1;
            number = KW_NUM_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/keyword_identifier_lexer_core.sv]
// Byte-serial lexer. Each req_ transfer carries one text byte. An operator byte
// (+ - * / % = < > & |) gives one rsp_ transfer of kind operator. Letters and digits
// are collected in a word store of WORD_CAPACITY entries (extra ones are dropped); a
// whitespace, semicolon or comma byte ends a non-empty word, which is then sent one
// character per rsp_ transfer, tagged keyword (with its number among int float if else
// while do for return char double) or identifier, with last_of_token on the final one.
// Timing: a delimiter that ends a word holds req_ready low while the word is read back,
// one character per cycle through the single read port of the word store; rsp_ready low
// stretches this. The keyword check runs while the word is collected, one character
// compare per stored byte, so the emission starts right away. The word store needs no
// clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module keyword_identifier_lexer_core import kil_pkg::*; #(
   parameter int WORD_CAPACITY = DEFAULT_WORD_CAPACITY
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_token_kind,
   output logic [3:0]      rsp_keyword_number,
   output logic [7:0]      rsp_token_char,
   output logic            rsp_last_of_token
);

   localparam int LEN_W  = $clog2(WORD_CAPACITY + 1);
   localparam int ADDR_W = $clog2(WORD_CAPACITY);

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   token_kind_type       kind_ff, kind_in;
   logic [KW_NUM_W-1:0]  num_ff, num_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;

   logic             accept;
   logic             out_free;
   logic             store;
   logic             load;
   logic             issue;
   logic             is_last;
   logic [7:0]       rd_data;
   logic             kw_hit;
   logic [KW_NUM_W-1:0] kw_num;

   // Take a byte only while idle and with room in the result register.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign store = accept && is_word_char(req_text_byte) &&
                  (len_ff < LEN_W'(WORD_CAPACITY));

   // Emission: one store read in flight ahead of the result register.
   assign load    = (state_ff == ST_EMIT) && pend_ff && out_free;
   assign issue   = (state_ff == ST_EMIT) && (!pend_ff || load) && (rd_idx_ff < len_ff);
   assign is_last = (rd_idx_ff == len_ff);

   kil_word_ram #(
      .DEPTH  (WORD_CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_text_byte),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   kil_kw_match #(
      .LEN_W (LEN_W)
   ) u_kw_match (
      .clock    (clock),
      .step     (store),
      .char_in  (req_text_byte),
      .word_len (len_ff),
      .hit      (kw_hit),
      .number   (kw_num)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      num_in       = num_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_op_char(req_text_byte)) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_OPERATOR;
                  num_in       = '0;
                  char_in      = req_text_byte;
                  last_in      = 1'b1;
               end else if (is_word_char(req_text_byte)) begin
                  // Drop letters past capacity.
                  if (store) begin
                     len_in = len_ff + LEN_W'(1);
                  end
               end else if (is_end_char(req_text_byte) && (len_ff != '0)) begin
                  state_in  = ST_EMIT;
                  rd_idx_in = '0;
                  pend_in   = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + LEN_W'(1);
            end
            pend_in = issue || (pend_ff && !load);
            if (load) begin
               rsp_valid_in = 1'b1;
               kind_in      = kw_hit ? KIND_KEYWORD : KIND_IDENTIFIER;
               num_in       = kw_hit ? kw_num : '0;
               char_in      = rd_data;
               last_in      = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
                  len_in   = '0;
                  pend_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      num_ff  <= num_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_token_kind     = kind_ff;
   assign rsp_keyword_number = num_ff;
   assign rsp_token_char     = char_ff;
   assign rsp_last_of_token  = last_ff;

   `ASSERT_NEVER(a_len_bound, clock, reset, len_ff > LEN_W'(WORD_CAPACITY))
   `ASSERT_HOLDS(a_pend_in_emit, clock, reset, !pend_ff || (state_ff == ST_EMIT))
   `ASSERT_HOLDS(a_end_idle, clock, reset, (load && is_last) |=> (state_ff == ST_IDLE))
   `ASSERT_HOLDS(a_end_rsp, clock, reset, (load && is_last) |=> (rsp_valid && rsp_last_of_token))
   `ASSERT_HOLDS(a_rd_idx_bound, clock, reset, (state_ff != ST_EMIT) || (rd_idx_ff <= len_ff))

endmodule

`default_nettype wire
